// ===== hdl/wis_pkg.sv =====
// ----------------------------------------------------------------------------
// wis_pkg
// Shared widths, operation codes and item structs for the weighted index
// sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package wis_pkg;

	localparam int WEIGHT_BITS = 32;
	localparam int FRAC_BITS   = 32;
	localparam int IDX_BITS    = 10;
	localparam int SEL_BITS    = 11;
	localparam int NUM_BITS    = 11;

	// stream payload widths, rounded up to whole bytes
	localparam int IN_FIELD_BITS  = IDX_BITS + WEIGHT_BITS + FRAC_BITS;
	localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_BITS = ((SEL_BITS + 7) / 8) * 8;

	// operation codes carried in the input tuser
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// status codes carried in the output tuser
	localparam logic ST_FOUND    = 1'b0;
	localparam logic ST_NOTFOUND = 1'b1;

	typedef struct packed {
		logic                   op;
		logic [IDX_BITS-1:0]    entry_index;
		logic [WEIGHT_BITS-1:0] weight_value;
		logic [FRAC_BITS-1:0]   random_fraction;
	} req_t;

	typedef struct packed {
		logic [SEL_BITS-1:0] selected_index;
		logic                status;
	} res_t;

endpackage

`default_nettype wire

// ===== hdl/weighted_index_sampler.sv =====
// ----------------------------------------------------------------------------
// weighted_index_sampler
// Inverse-CDF index sampling by lower-bound search over a table of
// nondecreasing cumulative weights.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries items: tuser selects the operation. A write item stores
//   weight_value at entry_index and gives no result. A sample item scales
//   random_fraction by the last entry in use into a target from 1 to the
//   total and returns the first index whose weight reaches it on m_axis.
//   status is set, and the index equals the entry count, when nothing does.
//   cfg sets the entry count (0 acts as 1, above TABLE_DEPTH saturates);
//   write it only while the block is idle. cfg_ready is always high.
//   A write item leaves the block idle, ready for the next item. A sample
//   item holds s_axis_tready low from its transfer through one read of
//   the total, one multiply, then k search steps, where k is at most
//   floor(log2(n)) + 1 (11 for 1024 entries), each one table read through
//   the weight memory's single read port, then the handoff to the output.
//   The output register lets the next item enter while a result waits; a
//   stalled receiver blocks only the next result handoff.
//   Reset clears the entry count to 1 and empties the output; the table is
//   not cleared, so read no entry before writing it.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_index_sampler #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input item stream
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// [9:0] entry_index, [41:10] weight_value, [73:42] random_fraction
	input  wire logic [wis_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,
	// [0] operation
	input  wire logic                                s_axis_tuser,
	// result stream
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// [10:0] selected_index
	output logic [wis_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,
	// [0] status
	output logic                                     m_axis_tuser,
	// entry count register
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [wis_pkg::NUM_BITS-1:0]        cfg_data
);
	import wis_pkg::*;

	logic [NUM_BITS-1:0] num_entries_q;
	req_t                req;
	res_t                res;
	logic                res_valid;
	logic                res_ready;
	logic                m_valid_q;
	res_t                m_res_q;

	// take a register transfer in any cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_entries_q <= NUM_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			num_entries_q <= cfg_data;
		end
	end

	// unpack the input item, lowest field first
	assign req.op              = s_axis_tuser;
	assign req.entry_index     = s_axis_tdata[IDX_BITS-1:0];
	assign req.weight_value    = s_axis_tdata[IDX_BITS+WEIGHT_BITS-1:IDX_BITS];
	assign req.random_fraction = s_axis_tdata[IN_FIELD_BITS-1:IDX_BITS+WEIGHT_BITS];

	wis_core #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req         (req),
		.num_entries (num_entries_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register: load when empty or draining this cycle, else hold
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_BITS-SEL_BITS){1'b0}}, m_res_q.selected_index};
	assign m_axis_tuser  = m_res_q.status;

	// the padding bits of s_axis_tdata above the fields are ignored

endmodule

`default_nettype wire

// ===== hdl/wis_core.sv =====
// ----------------------------------------------------------------------------
// wis_core
// Weight table memory and the lower-bound search sequencer: one table read
// per search step, compare and next address in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wis_core #(
	parameter int TABLE_DEPTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire wis_pkg::req_t                 req,
	input  wire logic [wis_pkg::NUM_BITS-1:0]  num_entries,
	output logic                               res_valid,
	input  wire logic                          res_ready,
	output wis_pkg::res_t                      res
);
	import wis_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_TOT  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_SRCH = 5'b01000,
		ST_RES  = 5'b10000
	} state_t;

	state_t state_q;

	logic [WEIGHT_BITS-1:0]           mem [TABLE_DEPTH];
	logic [WEIGHT_BITS-1:0]           rd_data_q;
	logic [AW-1:0]                    rd_addr;
	logic [AW-1:0]                    wr_addr;
	logic                             wr_en;
	logic                             accept;

	logic [CW-1:0]                    n_clamp;
	logic [CW-1:0]                    n_q;
	logic [CW-1:0]                    lo_q;
	logic [CW-1:0]                    hi_q;
	logic [CW-1:0]                    mid_q;
	logic [CW-1:0]                    lo_nx;
	logic [CW-1:0]                    hi_nx;
	logic [CW-1:0]                    mid_nx;
	logic                             below;

	logic [FRAC_BITS-1:0]             frac_q;
	logic [FRAC_BITS+WEIGHT_BITS-1:0] prod_q;
	logic [WEIGHT_BITS-1:0]           target_q;
	res_t                             res_q;

	assign accept    = req_valid && req_ready;
	assign req_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RES);
	assign res       = res_q;

	// clamp the entry count to 1..TABLE_DEPTH
	always_comb begin
		priority if (num_entries == '0) begin
			n_clamp = CW'(1);
		end else if (32'(num_entries) > TABLE_DEPTH) begin
			n_clamp = CW'(TABLE_DEPTH);
		end else begin
			n_clamp = CW'(num_entries);
		end
	end

	assign wr_en   = accept && (req.op == OP_WRITE) && (32'(req.entry_index) < TABLE_DEPTH);
	assign wr_addr = AW'(req.entry_index);

	// one search step
	assign below  = rd_data_q < target_q;
	assign lo_nx  = below ? mid_q + CW'(1) : lo_q;
	assign hi_nx  = below ? hi_q : mid_q;
	assign mid_nx = lo_nx + ((hi_nx - lo_nx) >> 1);

	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = AW'(n_clamp - CW'(1));
			ST_MUL:  rd_addr = AW'(n_q >> 1);
			default: rd_addr = AW'(mid_nx);
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= WEIGHT_BITS'(req.weight_value);
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (req.op == OP_SAMPLE)) begin
						state_q <= ST_TOT;
					end
				end
				ST_TOT:  state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_SRCH;
				ST_SRCH: begin
					if (!(lo_nx < hi_nx)) begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				frac_q <= req.random_fraction;
				n_q    <= n_clamp;
			end
			ST_TOT: begin
				prod_q <= frac_q * rd_data_q;
			end
			ST_MUL: begin
				target_q <= prod_q[FRAC_BITS+WEIGHT_BITS-1:FRAC_BITS] + WEIGHT_BITS'(1);
				lo_q     <= '0;
				hi_q     <= n_q;
				mid_q    <= n_q >> 1;
			end
			ST_SRCH: begin
				lo_q  <= lo_nx;
				hi_q  <= hi_nx;
				mid_q <= mid_nx;
				res_q.selected_index <= SEL_BITS'(lo_nx);
				res_q.status         <= (lo_nx == n_q) ? ST_NOTFOUND : ST_FOUND;
			end
			default: begin
			end
		endcase
	end

	a_srch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> lo_q < hi_q)
		else $error("search window empty while searching");

	a_mid_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> mid_q >= lo_q && mid_q < hi_q)
		else $error("probe outside search window");

	a_hi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> hi_q <= n_q)
		else $error("search bound beyond entry count");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RES && !res_ready |=> state_q == ST_RES && $stable(res_q))
		else $error("result dropped before handoff");

endmodule

`default_nettype wire
